// ===== design/bch_63_45_codec_top_macros.svh =====
`ifndef BCH_63_45_CODEC_TOP_MACROS_SVH
`define BCH_63_45_CODEC_TOP_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define BCH_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define BCH_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/bch_pkg.sv =====
`timescale 1ns / 1ps
package bch_pkg;

   localparam int CodeN      = 63;
   localparam int MsgK       = 45;
   localparam int ParityBits = 18;

   localparam logic [6:0]  FIELD_POLY    = 7'h43;
   localparam logic [18:0] GEN_POLY      = 19'h782CF;
   localparam logic [2:0]  UNCORRECTABLE = 3'd4;

   typedef logic [5:0] gf_type;
   typedef logic [6:1][5:0] synd_type;
   typedef logic [3:0][5:0] lam_type;
   typedef logic [8:0][5:0] mat_type;
   typedef logic [2:0][5:0] tri_type;

   typedef struct packed {
      logic [1:0] deg;
      lam_type    lam;
   } loc_type;

   typedef enum logic {
      CMD_ENCODE = 1'b0,
      CMD_DECODE = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_SOLVE,
      ST_SEARCH,
      ST_DONE
   } state_type;

   // alpha^k for k = 1..6 and alpha^-k for k = 1..3
   localparam gf_type ALPHA_POW [1:6] = '{6'h02, 6'h04, 6'h08, 6'h10, 6'h20, 6'h03};
   localparam gf_type ALPHA_NEG [1:3] = '{6'h21, 6'h31, 6'h39};

   // GF(64) product, reduced by x^6+x+1
   function automatic gf_type gf_mul(gf_type a, gf_type b);
      logic [10:0] p;
      p = '0;
      for (int i = 0; i < 6; i++) begin
         if (b[i]) p = p ^ (11'(a) << i);
      end
      for (int i = 10; i >= 6; i--) begin
         if (p[i]) p = p ^ (11'(FIELD_POLY) << (i - 6));
      end
      return p[5:0];
   endfunction

   // Inverse as a^62; zero maps to zero
   function automatic gf_type gf_inv(gf_type a);
      gf_type sq;
      gf_type acc;
      sq  = a;
      acc = 6'd1;
      for (int i = 0; i < 5; i++) begin
         sq  = gf_mul(sq, sq);
         acc = gf_mul(acc, sq);
      end
      return acc;
   endfunction

endpackage

// ===== design/bch_serial.sv =====
`timescale 1ns / 1ps
module bch_serial import bch_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  cmd_type               cmd,
   input  logic [MsgK-1:0]       message,
   input  logic [CodeN-1:0]      received_word,
   output logic                  done,
   output logic [CodeN-1:0]      word,
   output logic [ParityBits-1:0] parity,
   output synd_type              syn
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [5:0]            cnt_ff, cnt_in;
   logic [CodeN-1:0]      word_ff, word_in;
   logic [ParityBits-1:0] par_ff, par_in;
   synd_type              syn_ff, syn_in;
   logic                  bit_now;
   logic                  fb;

   assign bit_now = word_ff[CodeN-1];
   assign fb      = bit_now ^ par_ff[ParityBits-1];

   // Shift one bit a cycle through the division register and the syndromes
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      word_in = word_ff;
      par_in  = par_ff;
      syn_in  = syn_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         word_in = (cmd == CMD_DECODE) ? received_word
                                       : {message, {ParityBits{1'b0}}};
         par_in  = '0;
         syn_in  = '0;
      end else if (busy_ff) begin
         word_in = {word_ff[CodeN-2:0], bit_now};
         for (int k = 1; k <= 6; k++) begin
            syn_in[k] = gf_mul(syn_ff[k], ALPHA_POW[k]) ^ {5'b0, bit_now};
         end
         if (cnt_ff < 6'(MsgK)) begin
            par_in = {par_ff[ParityBits-2:0], 1'b0}
                     ^ (fb ? GEN_POLY[ParityBits-1:0] : '0);
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(CodeN - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      word_ff <= word_in;
      par_ff  <= par_in;
      syn_ff  <= syn_in;
   end

   assign done   = done_ff;
   assign word   = word_ff;
   assign parity = par_ff;
   assign syn    = syn_ff;

endmodule

// ===== design/bch_pgz.sv =====
`timescale 1ns / 1ps
module bch_pgz import bch_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  synd_type syn,
   output logic     loc_valid,
   output loc_type  loc
);

   logic [3:0] vld_ff;
   mat_type    mats [4];

   // Stage one registers
   tri_type row_ff [4];
   tri_type minor_ff [4];
   gf_type  d2_ff, n1_ff, n2_ff, s1_ff, s2_ff;
   // Stage two registers
   gf_type  det_ff [4];
   gf_type  d2b_ff, n1b_ff, n2b_ff, s1b_ff, s2b_ff;
   // Stage three registers
   gf_type  detc_ff [4];
   gf_type  invd_ff, invd2_ff, invs1_ff;
   gf_type  d2c_ff, n1c_ff, n2c_ff, s1c_ff, s2c_ff;
   // Output register
   loc_type loc_ff, loc_in;

   // Build the syndrome matrix and its three Cramer variants
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         mats[c] = {syn[5], syn[4], syn[3], syn[4], syn[3], syn[2], syn[3], syn[2], syn[1]};
      end
      for (int c = 0; c < 3; c++) begin
         for (int r = 0; r < 3; r++) begin
            mats[c+1][r*3+c] = syn[4+r];
         end
      end
   end

   // Advance the valid marker along the stages
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[2:0], start};
      end
   end

   // Stage one: row values and 2x2 minors
   always_ff @(posedge clock) begin
      for (int c = 0; c < 4; c++) begin
         row_ff[c]      <= {mats[c][2], mats[c][1], mats[c][0]};
         minor_ff[c][0] <= gf_mul(mats[c][4], mats[c][8]) ^ gf_mul(mats[c][5], mats[c][7]);
         minor_ff[c][1] <= gf_mul(mats[c][3], mats[c][8]) ^ gf_mul(mats[c][5], mats[c][6]);
         minor_ff[c][2] <= gf_mul(mats[c][3], mats[c][7]) ^ gf_mul(mats[c][4], mats[c][6]);
      end
      d2_ff <= gf_mul(syn[1], syn[3]) ^ gf_mul(syn[2], syn[2]);
      n1_ff <= gf_mul(syn[1], syn[4]) ^ gf_mul(syn[2], syn[3]);
      n2_ff <= gf_mul(syn[2], syn[4]) ^ gf_mul(syn[3], syn[3]);
      s1_ff <= syn[1];
      s2_ff <= syn[2];
   end

   // Stage two: determinants
   always_ff @(posedge clock) begin
      for (int c = 0; c < 4; c++) begin
         det_ff[c] <= gf_mul(row_ff[c][0], minor_ff[c][0])
                    ^ gf_mul(row_ff[c][1], minor_ff[c][1])
                    ^ gf_mul(row_ff[c][2], minor_ff[c][2]);
      end
      d2b_ff <= d2_ff;
      n1b_ff <= n1_ff;
      n2b_ff <= n2_ff;
      s1b_ff <= s1_ff;
      s2b_ff <= s2_ff;
   end

   // Stage three: inverses of the divisors
   always_ff @(posedge clock) begin
      for (int c = 0; c < 4; c++) begin
         detc_ff[c] <= det_ff[c];
      end
      invd_ff  <= gf_inv(det_ff[0]);
      invd2_ff <= gf_inv(d2b_ff);
      invs1_ff <= gf_inv(s1b_ff);
      d2c_ff   <= d2b_ff;
      n1c_ff   <= n1b_ff;
      n2c_ff   <= n2b_ff;
      s1c_ff   <= s1b_ff;
      s2c_ff   <= s2b_ff;
   end

   // Stage four: pick the largest degree that fits
   always_comb begin
      loc_in.deg = 2'd0;
      loc_in.lam = '0;
      loc_in.lam[0] = 6'd1;
      if (detc_ff[0] != '0) begin
         loc_in.deg    = 2'd3;
         loc_in.lam[3] = gf_mul(detc_ff[1], invd_ff);
         loc_in.lam[2] = gf_mul(detc_ff[2], invd_ff);
         loc_in.lam[1] = gf_mul(detc_ff[3], invd_ff);
      end else if (d2c_ff != '0) begin
         loc_in.deg    = 2'd2;
         loc_in.lam[1] = gf_mul(n1c_ff, invd2_ff);
         loc_in.lam[2] = gf_mul(n2c_ff, invd2_ff);
      end else if (s1c_ff != '0) begin
         loc_in.deg    = 2'd1;
         loc_in.lam[1] = gf_mul(s2c_ff, invs1_ff);
      end
   end

   always_ff @(posedge clock) begin
      loc_ff <= loc_in;
   end

   assign loc_valid = vld_ff[3];
   assign loc       = loc_ff;

endmodule

// ===== design/bch_chien.sv =====
`timescale 1ns / 1ps
module bch_chien import bch_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  loc_type          loc,
   input  logic [CodeN-1:0] word_in_data,
   output logic             done,
   output logic [CodeN-1:0] word_out,
   output logic [1:0]       found
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic [1:0]       found_ff, found_in;
   logic [1:0]       deg_ff, deg_in;
   lam_type          term_ff, term_in;
   logic [CodeN-1:0] word_ff, word_in;
   gf_type           val;
   logic             root;

   assign val  = term_ff[0] ^ term_ff[1] ^ term_ff[2] ^ term_ff[3];
   assign root = (val == '0) && (found_ff < deg_ff);

   // Test one position a cycle, rotating the word so that it sits at bit 0
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      found_in = found_ff;
      deg_in   = deg_ff;
      term_in  = term_ff;
      word_in  = word_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         found_in = '0;
         deg_in   = loc.deg;
         term_in  = loc.lam;
         word_in  = word_in_data;
      end else if (busy_ff) begin
         word_in = {word_ff[0] ^ root, word_ff[CodeN-1:1]};
         for (int k = 1; k <= 3; k++) begin
            term_in[k] = gf_mul(term_ff[k], ALPHA_NEG[k]);
         end
         if (root) found_in = found_ff + 2'd1;
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(CodeN - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
         found_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
         found_ff <= found_in;
      end
      deg_ff  <= deg_in;
      term_ff <= term_in;
      word_ff <= word_in;
   end

   assign done     = done_ff;
   assign word_out = word_ff;
   assign found    = found_ff;

endmodule

// ===== design/bch_63_45_codec_top.sv =====
`timescale 1ns / 1ps
// BCH(63,45) codec, up to three bit errors corrected.
// Request channel (req_): req_cmd selects encode (0) or decode (1), with
// req_message or req_received_word as the operand. A transfer takes place
// when req_valid is high and req_stall is low; the block takes one request
// at a time and holds req_stall high until that request is finished.
// Result channel (rsp_): code word, its upper 45 bits, error count (0..3,
// 4 when uncorrectable) and the correctable flag, transferred when
// rsp_valid is high and rsp_stall is low.
// The bit-serial pass over all 63 bit positions sets the pace. Encode
// and a clean decode make that pass only; a decode with errors adds
// locator solving and, when a locator is found, a Chien search over the
// 63 positions.
// The output register holds a finished result while the receiver stalls;
// a new request is taken meanwhile, but its result waits for the register.
// Reset is synchronous and clears all control state; no result is pending.
`include "bch_63_45_codec_top_macros.svh"
module bch_63_45_codec_top import bch_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_cmd,
   input  logic [MsgK-1:0]  req_message,
   input  logic [CodeN-1:0] req_received_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [CodeN-1:0] rsp_code_word,
   output logic [MsgK-1:0]  rsp_message_out,
   output logic [2:0]       rsp_error_count,
   output logic             rsp_correctable
);

   state_type             state_ff, state_in;
   cmd_type               cmd_ff;
   logic                  ser_start, ser_done;
   logic [CodeN-1:0]      ser_word;
   logic [ParityBits-1:0] ser_parity;
   synd_type              ser_syn;
   logic                  pgz_start, pgz_valid;
   loc_type               pgz_loc;
   logic                  chien_start, chien_done;
   logic [CodeN-1:0]      chien_word;
   logic [1:0]            chien_found;
   logic [1:0]            deg_ff;
   logic [CodeN-1:0]      res_word_ff;
   logic [2:0]            res_count_ff;
   logic                  res_ok_ff;
   logic                  rsp_valid_ff;
   logic [CodeN-1:0]      rsp_word_ff;
   logic [2:0]            rsp_count_ff;
   logic                  rsp_ok_ff;
   logic                  out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   bch_serial u_serial (
      .clock         (clock),
      .reset         (reset),
      .start         (ser_start),
      .cmd           (cmd_type'(req_cmd)),
      .message       (req_message),
      .received_word (req_received_word),
      .done          (ser_done),
      .word          (ser_word),
      .parity        (ser_parity),
      .syn           (ser_syn)
   );

   bch_pgz u_pgz (
      .clock     (clock),
      .reset     (reset),
      .start     (pgz_start),
      .syn       (ser_syn),
      .loc_valid (pgz_valid),
      .loc       (pgz_loc)
   );

   bch_chien u_chien (
      .clock        (clock),
      .reset        (reset),
      .start        (chien_start),
      .loc          (pgz_loc),
      .word_in_data (ser_word),
      .done         (chien_done),
      .word_out     (chien_word),
      .found        (chien_found)
   );

   // Sequence the passes and raise the start strobes
   always_comb begin
      state_in    = state_ff;
      ser_start   = 1'b0;
      pgz_start   = 1'b0;
      chien_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ser_start = 1'b1;
               state_in  = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (ser_done) begin
               if (cmd_ff == CMD_ENCODE || ser_syn == '0) begin
                  state_in = ST_DONE;
               end else begin
                  pgz_start = 1'b1;
                  state_in  = ST_SOLVE;
               end
            end
         end
         ST_SOLVE: begin
            if (pgz_valid) begin
               if (pgz_loc.deg == 2'd0) begin
                  state_in = ST_DONE;
               end else begin
                  chien_start = 1'b1;
                  state_in    = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (chien_done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Hold the request command and collect the result of each pass
   always_ff @(posedge clock) begin
      if (ser_start) cmd_ff <= cmd_type'(req_cmd);
      if (chien_start) deg_ff <= pgz_loc.deg;
      if (state_ff == ST_SHIFT && ser_done) begin
         res_word_ff  <= (cmd_ff == CMD_ENCODE)
                         ? {ser_word[CodeN-1:ParityBits], ser_parity} : ser_word;
         res_count_ff <= 3'd0;
         res_ok_ff    <= 1'b1;
      end
      if (state_ff == ST_SOLVE && pgz_valid && pgz_loc.deg == 2'd0) begin
         res_count_ff <= UNCORRECTABLE;
         res_ok_ff    <= 1'b0;
      end
      if (state_ff == ST_SEARCH && chien_done) begin
         if (chien_found == deg_ff) begin
            res_word_ff  <= chien_word;
            res_count_ff <= {1'b0, deg_ff};
            res_ok_ff    <= 1'b1;
         end else begin
            res_count_ff <= UNCORRECTABLE;
            res_ok_ff    <= 1'b0;
         end
      end
   end

   // Load the output register when free, drop valid after the transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (state_ff == ST_DONE && out_free) begin
         rsp_word_ff  <= res_word_ff;
         rsp_count_ff <= res_count_ff;
         rsp_ok_ff    <= res_ok_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_code_word   = rsp_word_ff;
   assign rsp_message_out = rsp_word_ff[CodeN-1:ParityBits];
   assign rsp_error_count = rsp_count_ff;
   assign rsp_correctable = rsp_ok_ff;

   `BCH_ASSERT_NXT(a_req_starts_shift, req_valid && !req_stall, state_ff == ST_SHIFT, "accepted request did not start the shift pass")
   `BCH_ASSERT_IMP(a_chien_in_search, chien_done, state_ff == ST_SEARCH, "Chien search finished outside the search state")
   `BCH_ASSERT_IMP(a_flag_matches_count, rsp_valid, rsp_correctable == (rsp_error_count != UNCORRECTABLE), "correctable flag disagrees with error count")

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
   import bch_pkg::*;

   localparam int CycleLimit = 4_000_000;
   localparam int HoldCycles = 700;

   typedef struct {
      cmd_type         cmd;
      logic [44:0]     message;
      logic [62:0]     word;
   } codec_req_type;

   typedef struct {
      logic [62:0] code_word;
      logic [44:0] message_out;
      logic [2:0]  error_count;
      logic        correctable;
   } codec_rsp_type;

   logic             clock;
   logic             reset;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic             req_cmd = 1'b0;
   logic [44:0]      req_message = '0;
   logic [62:0]      req_received_word = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [62:0]      rsp_code_word;
   logic [44:0]      rsp_message_out;
   logic [2:0]       rsp_error_count;
   logic             rsp_correctable;

   codec_req_type pending_reqs[$];
   codec_rsp_type expected_rsps[$];
   int         send_idle_pct;
   int         recv_stall_pct;
   int         accepted = 0;
   int         hold_left = 0;
   bit         hold_done = 1'b0;
   int         errors = 0;
   longint     cycles = 0;

   // field tables and generator, built independently of the design
   logic [5:0]  alog[0:63];
   int          glog[0:63];
   logic [18:0] generator;

   bch_63_45_codec_top i_dut (.*);

   // clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [5:0] fmul(logic [5:0] a, logic [5:0] b);
      if (a == 0 || b == 0) return 6'd0;
      return alog[(glog[a] + glog[b]) % 63];
   endfunction

   function automatic logic [5:0] fdiv(logic [5:0] a, logic [5:0] b);
      if (a == 0 || b == 0) return 6'd0;
      return alog[(glog[a] + 63 - glog[b]) % 63];
   endfunction

   function automatic logic [31:0] carryless(logic [31:0] a, logic [31:0] b);
      logic [31:0] r;
      r = '0;
      for (int i = 0; i < 16; i++) if (b[i]) r ^= a << i;
      return r;
   endfunction

   // minimal polynomial of alpha^k as a bit mask over GF(2)
   function automatic logic [31:0] min_poly_mask(int k);
      logic [5:0]  c[0:7];
      logic [5:0]  nx[0:7];
      int          len;
      int          v;
      logic [31:0] bits;
      len = 1;
      v = k % 63;
      bits = '0;
      foreach (c[i]) c[i] = 6'd0;
      c[0] = 6'd1;
      for (int n = 0; n < 6; n++) begin
         foreach (nx[i]) nx[i] = 6'd0;
         for (int i = 0; i < len; i++) begin
            nx[i+1] ^= c[i];
            nx[i] ^= fmul(c[i], alog[v]);
         end
         len++;
         for (int i = 0; i < len; i++) c[i] = nx[i];
         v = (v * 2) % 63;
         if (v == k % 63) break;
      end
      for (int i = 0; i < len; i++) if (c[i] != 0) bits[i] = 1'b1;
      return bits;
   endfunction

   function automatic void build_field();
      logic [6:0]  x;
      logic [31:0] g;
      x = 7'd1;
      for (int i = 0; i < 63; i++) begin
         alog[i] = x[5:0];
         glog[x[5:0]] = i;
         x = x << 1;
         if (x[6]) x ^= 7'h43;
      end
      alog[63] = 6'd1;
      glog[0] = 0;
      g = carryless(carryless(min_poly_mask(1), min_poly_mask(3)), min_poly_mask(5));
      generator = g[18:0];
   endfunction

   function automatic logic [62:0] systematic_encode(logic [44:0] msg);
      logic [62:0] r;
      r = {msg, 18'd0};
      for (int i = 62; i >= 18; i--)
         if (r[i]) r ^= 63'(generator) << (i - 18);
      return {msg, r[17:0]};
   endfunction

   function automatic logic [5:0] det3(logic [5:0] m[0:8]);
      return fmul(m[0], fmul(m[4], m[8]) ^ fmul(m[5], m[7]))
           ^ fmul(m[1], fmul(m[3], m[8]) ^ fmul(m[5], m[6]))
           ^ fmul(m[2], fmul(m[3], m[7]) ^ fmul(m[4], m[6]));
   endfunction

   // expected result of one request
   function automatic codec_rsp_type predict_codec(codec_req_type rq);
      codec_rsp_type rs;
      logic [62:0] w;
      logic [5:0]  s[1:6];
      logic [5:0]  lam[0:3];
      logic [5:0]  m[0:8];
      logic [5:0]  t[0:8];
      logic [5:0]  d;
      logic [5:0]  val;
      int          deg;
      int          found;
      int          pos[0:2];
      int          neg;
      rs.error_count = 3'd0;
      rs.correctable = 1'b1;
      if (rq.cmd == CMD_ENCODE) begin
         w = systematic_encode(rq.message);
      end else begin
         w = rq.word;
         foreach (s[k]) s[k] = 6'd0;
         for (int j = 62; j >= 0; j--)
            for (int k = 1; k <= 6; k++) s[k] = fmul(s[k], alog[k]) ^ {5'd0, w[j]};
         if ((s[1] | s[2] | s[3] | s[4] | s[5] | s[6]) != 0) begin
            foreach (lam[k]) lam[k] = 6'd0;
            lam[0] = 6'd1;
            m = '{s[1], s[2], s[3], s[2], s[3], s[4], s[3], s[4], s[5]};
            d = det3(m);
            deg = 0;
            if (d != 0) begin
               for (int col = 0; col < 3; col++) begin
                  t = m;
                  for (int r = 0; r < 3; r++) t[r*3+col] = s[4+r];
                  lam[3-col] = fdiv(det3(t), d);
               end
               deg = 3;
            end else begin
               d = fmul(s[1], s[3]) ^ fmul(s[2], s[2]);
               if (d != 0) begin
                  lam[1] = fdiv(fmul(s[1], s[4]) ^ fmul(s[2], s[3]), d);
                  lam[2] = fdiv(fmul(s[2], s[4]) ^ fmul(s[3], s[3]), d);
                  deg = 2;
               end else if (s[1] != 0) begin
                  lam[1] = fdiv(s[2], s[1]);
                  deg = 1;
               end
            end
            // search the locator roots at alpha^-j
            found = 0;
            for (int j = 0; j < 63 && deg != 0 && found < deg; j++) begin
               neg = (63 - j) % 63;
               val = 6'd0;
               for (int k = 0; k <= deg; k++) val ^= fmul(lam[k], alog[(k * neg) % 63]);
               if (val == 0) begin
                  pos[found] = j;
                  found++;
               end
            end
            if (deg == 0 || found != deg) begin
               rs.error_count = UNCORRECTABLE;
               rs.correctable = 1'b0;
            end else begin
               for (int k = 0; k < found; k++) w[pos[k]] = ~w[pos[k]];
               rs.error_count = 3'(deg);
            end
         end
      end
      rs.code_word = w;
      rs.message_out = w[62:18];
      return rs;
   endfunction

   function automatic logic [44:0] rand_msg();
      return 45'({$urandom, $urandom});
   endfunction

   function automatic logic [62:0] rand_word();
      return 63'({$urandom, $urandom});
   endfunction

   // flip n distinct bit positions
   function automatic logic [62:0] corrupt(logic [62:0] w, int n);
      logic [62:0] mask;
      int          p;
      mask = '0;
      for (int i = 0; i < n; i++) begin
         p = $urandom_range(62);
         while (mask[p]) p = $urandom_range(62);
         mask[p] = 1'b1;
      end
      return w ^ mask;
   endfunction

   function automatic void add_req(cmd_type c, logic [44:0] msg, logic [62:0] w);
      codec_req_type rq;
      rq.cmd = c;
      rq.message = msg;
      rq.word = w;
      pending_reqs.push_back(rq);
   endfunction

   // driver: present the next request once the last one was transferred
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_cmd <= 1'b0;
         req_message <= '0;
         req_received_word <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(predict_codec('{cmd_type'(req_cmd), req_message,
                                                    req_received_word}));
            accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               codec_req_type rq;
               rq = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_cmd <= rq.cmd;
               req_message <= rq.message;
               req_received_word <= rq.word;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall, with one long hold-off to back the block up
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && accepted >= 150) begin
         hold_done <= 1'b1;
         hold_left <= HoldCycles;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // monitor: check each transfer against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result, code_word %h", $time, rsp_code_word);
            errors++;
         end else begin
            codec_rsp_type ex;
            ex = expected_rsps.pop_front();
            if (rsp_code_word !== ex.code_word) begin
               $display("%0t: code_word expected %h actual %h", $time, ex.code_word,
                        rsp_code_word);
               errors++;
            end
            if (rsp_message_out !== ex.message_out) begin
               $display("%0t: message_out expected %h actual %h", $time, ex.message_out,
                        rsp_message_out);
               errors++;
            end
            if (rsp_error_count !== ex.error_count) begin
               $display("%0t: error_count expected %0d actual %0d", $time, ex.error_count,
                        rsp_error_count);
               errors++;
            end
            if (rsp_correctable !== ex.correctable) begin
               $display("%0t: correctable expected %0d actual %0d", $time, ex.correctable,
                        rsp_correctable);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("FAIL bch_63_45_codec_top");
         $finish;
      end
   end

   initial begin
      logic [62:0] cw;
      int          n;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1'b1;
      build_field();

      // directed: field extremes, clean words, 1..3 errors, beyond capacity
      add_req(CMD_ENCODE, '0, '0);
      add_req(CMD_ENCODE, '1, '0);
      add_req(CMD_ENCODE, 45'h0AAA_AAAA_AAAA, '1);
      add_req(CMD_ENCODE, 45'h1555_5555_5555, '0);
      add_req(CMD_DECODE, '1, '0);
      add_req(CMD_DECODE, '0, '1);
      cw = systematic_encode(45'h1234_5678_9ABC);
      add_req(CMD_DECODE, '0, cw);
      add_req(CMD_DECODE, '0, cw ^ 63'd1);
      add_req(CMD_DECODE, '0, cw ^ (63'd1 << 62));
      add_req(CMD_DECODE, '0, cw ^ 63'h4000_0000_0000_0001);
      add_req(CMD_DECODE, '0, cw ^ 63'h4000_0001_0000_0001);
      add_req(CMD_DECODE, '0, '0 ^ 63'h7);
      add_req(CMD_DECODE, '1, 63'h0000_0000_0000_0001);
      for (int e = 4; e <= 8; e++) add_req(CMD_DECODE, '0, corrupt(cw, e));
      add_req(CMD_DECODE, '0, 63'h5555_5555_5555_5555);
      add_req(CMD_DECODE, '0, 63'h2AAA_AAAA_AAAA_AAAA);
      for (int i = 0; i < 3; i++) add_req(CMD_DECODE, rand_msg(), rand_word());

      // random: mostly codewords with few errors, some encodes, some beyond capacity and noise
      for (int i = 0; i < 1500; i++) begin
         n = $urandom_range(99);
         if (n < 25) begin
            add_req(CMD_ENCODE, rand_msg(), rand_word());
         end else if (n < 85) begin
            add_req(CMD_DECODE, rand_msg(),
                    corrupt(systematic_encode(rand_msg()), $urandom_range(3)));
         end else if (n < 93) begin
            add_req(CMD_DECODE, rand_msg(),
                    corrupt(systematic_encode(rand_msg()), $urandom_range(10, 4)));
         end else begin
            add_req(CMD_DECODE, rand_msg(), rand_word());
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // advance through the idling phases
      while (pending_reqs.size() > 0) begin
         @(posedge clock);
         case (accepted / 380)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 58;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 58;
            end
            default: begin
               send_idle_pct = 26;
               recv_stall_pct = 26;
            end
         endcase
      end
      while (req_valid || expected_rsps.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("PASS bch_63_45_codec_top");
      end else begin
         $display("FAIL bch_63_45_codec_top");
      end
      $finish;
   end

endmodule
